### rtl/core/sfcd_pkg.sv
// Package for the sensor frame CRC decoder: constants, codes, the queued
// frame record type and the byte-wide CRC-8 update function.
// No dependencies.
`default_nettype none

package sfcd_pkg;

  localparam int BYTE_W        = 8;
  localparam int STORE_DEPTH   = 9;
  localparam int STORE_IDX_W   = $clog2(STORE_DEPTH);
  localparam int COUNT_W       = 4;
  localparam int CFG_INDEX_W   = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = 1;
  localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 4'hF;
  localparam logic [COUNT_W-1:0] CRC_BYTE_IDX = 4'd9;
  localparam logic [COUNT_W-1:0] LAST_IDX_MAX = 4'd10;

  localparam logic [7:0] MIN_ROW_BITS = 8'd80;
  localparam logic [7:0] MAX_ROW_BITS = 8'd82;

  localparam logic [7:0] POLY_RESET  = 8'h97;
  localparam logic [7:0] START_RESET = 8'h00;

  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLYNOMIAL  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_START_VALUE = 8'd1;

  localparam logic [3:0] FORMAT_BASIC    = 4'd0;
  localparam logic [3:0] FORMAT_EXTENDED = 4'd1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_LENGTH_ERR = 2'd1,
    STATUS_CRC_ERR    = 2'd2,
    STATUS_FORMAT_ERR = 2'd3
  } status_t;

  typedef struct packed {
    status_t                                status;
    logic [STORE_DEPTH-1:0][BYTE_W-1:0]     bytes;
  } frame_rec_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] rem, input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] r;
    r = rem ^ data;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sfcd_intf.sv
// Channel interfaces of the sensor frame CRC decoder: byte input, decoded
// result output and configuration write channel.
// Depends on sfcd_pkg.
`default_nettype none

interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] row_bit_count;
  logic       row_end;

  modport source(output valid, data_byte, row_bit_count, row_end, input ready);
  modport sink(input valid, data_byte, row_bit_count, row_end, output ready);
endinterface

interface sfcd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         format_code;
  logic [3:0]         device_id;
  logic signed [11:0] temp_first;
  logic signed [11:0] temp_second;
  logic [7:0]         humidity_first;
  logic [7:0]         humidity_second;
  logic [15:0]        pressure_tenths;
  logic [7:0]         supply_code;
  logic [63:0]        payload_raw;

  modport source(output valid, status, format_code, device_id, temp_first, temp_second,
                 humidity_first, humidity_second, pressure_tenths, supply_code,
                 payload_raw, input ready);
  modport sink(input valid, status, format_code, device_id, temp_first, temp_second,
               humidity_first, humidity_second, pressure_tenths, supply_code,
               payload_raw, output ready);
endinterface

interface sfcd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sfcd_pkg::CFG_INDEX_W-1:0]  index;
  logic [7:0]                        data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/sfcd_front.sv
// Front end: accepts row bytes, keeps the byte counter, running CRC-8 and
// byte store, and classifies each finished row into a queued record.
// Depends on sfcd_pkg and sfcd_intf.
`default_nettype none

module sfcd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  sfcd_in_if.sink                in_ch,
  sfcd_cfg_if.sink               cfg,
  input  wire logic              q_full,
  output sfcd_pkg::frame_rec_t   push_rec,
  output logic                   push
);

  localparam logic [sfcd_pkg::COUNT_W-1:0] CRC_IDX_EXT = sfcd_pkg::CRC_BYTE_IDX;

  logic [7:0]                          crc_polynomial;
  logic [7:0]                          crc_start_value;
  logic [sfcd_pkg::COUNT_W-1:0]        byte_counter;
  logic [7:0]                          crc_remainder;
  logic [sfcd_pkg::BYTE_W-1:0]         message_store [sfcd_pkg::STORE_DEPTH];
  logic [7:0]                          crc_next;
  logic                                accept;
  logic                                len_bad;
  sfcd_pkg::status_t                   status_next;

  assign in_ch.ready = !q_full;
  assign cfg.ready   = 1'b1;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && in_ch.row_end;

  always_comb begin
    if (byte_counter < CRC_IDX_EXT) begin
      crc_next = sfcd_pkg::crc_byte(crc_remainder, in_ch.data_byte, crc_polynomial);
    end else if (byte_counter == sfcd_pkg::CRC_BYTE_IDX) begin
      crc_next = crc_remainder ^ in_ch.data_byte;
    end else begin
      crc_next = crc_remainder;
    end
  end

  always_comb begin
    len_bad = !(byte_counter == sfcd_pkg::CRC_BYTE_IDX ||
                byte_counter == sfcd_pkg::LAST_IDX_MAX) ||
              in_ch.row_bit_count < sfcd_pkg::MIN_ROW_BITS ||
              in_ch.row_bit_count > sfcd_pkg::MAX_ROW_BITS;
    if (len_bad) begin
      status_next = sfcd_pkg::STATUS_LENGTH_ERR;
    end else if (crc_next != 8'd0) begin
      status_next = sfcd_pkg::STATUS_CRC_ERR;
    end else if (message_store[0][7:4] != sfcd_pkg::FORMAT_BASIC &&
                 message_store[0][7:4] != sfcd_pkg::FORMAT_EXTENDED) begin
      status_next = sfcd_pkg::STATUS_FORMAT_ERR;
    end else begin
      status_next = sfcd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    push_rec.status = status_next;
    for (int i = 0; i < sfcd_pkg::STORE_DEPTH; i++) begin
      push_rec.bytes[i] = message_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial  <= sfcd_pkg::POLY_RESET;
      crc_start_value <= sfcd_pkg::START_RESET;
      byte_counter    <= '0;
      crc_remainder   <= sfcd_pkg::START_RESET;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == sfcd_pkg::CFG_CRC_POLYNOMIAL) begin
          crc_polynomial <= cfg.data;
        end else if (cfg.index == sfcd_pkg::CFG_CRC_START_VALUE) begin
          crc_start_value <= cfg.data;
        end
      end
      if (accept) begin
        if (in_ch.row_end) begin
          byte_counter  <= '0;
          crc_remainder <= crc_start_value;
        end else begin
          crc_remainder <= crc_next;
          if (byte_counter != sfcd_pkg::COUNT_MAX) begin
            byte_counter <= byte_counter + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_counter < CRC_IDX_EXT) begin
      message_store[byte_counter[sfcd_pkg::STORE_IDX_W-1:0]] <= in_ch.data_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sfcd_queue.sv
// Two-entry queue of classified frame records between the front and back
// ends, so that each side can stall on its own.
// Depends on sfcd_pkg.
`default_nettype none

module sfcd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  sfcd_pkg::frame_rec_t       push_rec,
  input  wire logic                  pop,
  output logic                       full,
  output logic                       empty,
  output sfcd_pkg::frame_rec_t       head
);

  sfcd_pkg::frame_rec_t                    entries [sfcd_pkg::QUEUE_DEPTH];
  logic [sfcd_pkg::QUEUE_PTR_W-1:0]        wr_ptr;
  logic [sfcd_pkg::QUEUE_PTR_W-1:0]        rd_ptr;
  logic [sfcd_pkg::QUEUE_COUNT_W-1:0]      count;

  localparam logic [sfcd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
    sfcd_pkg::QUEUE_PTR_W'(sfcd_pkg::QUEUE_DEPTH - 1);
  localparam logic [sfcd_pkg::QUEUE_COUNT_W-1:0] COUNT_FULL =
    sfcd_pkg::QUEUE_COUNT_W'(sfcd_pkg::QUEUE_DEPTH);

  assign full  = count == COUNT_FULL;
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sfcd_back.sv
// Back end: takes a classified record from the queue, decodes the sensor
// fields by format and status, and holds them in the output register.
// Depends on sfcd_pkg and sfcd_intf.
`default_nettype none

module sfcd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  sfcd_pkg::frame_rec_t   head,
  output logic                   pop,
  sfcd_out_if.source             out_ch
);

  logic       valid;
  logic [3:0] fmt;
  logic       show_id;
  logic       show_basic;
  logic       show_ext;

  assign out_ch.valid = valid;
  assign pop          = !q_empty && (!valid || out_ch.ready);
  assign fmt          = head.bytes[0][7:4];
  assign show_id      = head.status == sfcd_pkg::STATUS_OK ||
                        head.status == sfcd_pkg::STATUS_FORMAT_ERR;
  assign show_basic   = head.status == sfcd_pkg::STATUS_OK;
  assign show_ext     = show_basic && fmt == sfcd_pkg::FORMAT_EXTENDED;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.status          <= head.status;
      out_ch.format_code     <= show_id ? fmt : 4'd0;
      out_ch.device_id       <= show_id ? head.bytes[0][3:0] : 4'd0;
      out_ch.temp_first      <= show_basic ? {head.bytes[1], head.bytes[2][7:4]} : 12'sd0;
      out_ch.supply_code     <= show_basic ? head.bytes[8] : 8'd0;
      out_ch.payload_raw     <= show_basic ? {head.bytes[1], head.bytes[2], head.bytes[3],
                                              head.bytes[4], head.bytes[5], head.bytes[6],
                                              head.bytes[7], head.bytes[8]} : 64'd0;
      out_ch.temp_second     <= show_ext ? {head.bytes[2][3:0], head.bytes[3]} : 12'sd0;
      out_ch.humidity_first  <= show_ext ? head.bytes[4] : 8'd0;
      out_ch.humidity_second <= show_ext ? head.bytes[5] : 8'd0;
      out_ch.pressure_tenths <= show_ext ? {head.bytes[6], head.bytes[7]} : 16'd0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sensor_frame_crc_decoder.sv
// Sensor frame CRC decoder, top level. One row byte is taken per cycle
// while the queue is not full; the CRC-8 update of a byte completes in the
// front end in its own cycle. A row's result passes from its final byte's
// transaction through a two-entry queue and the output register.
// Synchronous reset clears the counters, queue and output valid, and loads
// the CRC polynomial with 0x97 and the start value with 0x00.
`default_nettype none

module sensor_frame_crc_decoder (
  input  wire logic    clk,
  input  wire logic    rst,
  sfcd_in_if.sink      in_ch,
  sfcd_out_if.source   out_ch,
  sfcd_cfg_if.sink     cfg
);

  sfcd_pkg::frame_rec_t push_rec;
  sfcd_pkg::frame_rec_t head;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;

  sfcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_full   (q_full),
    .push_rec (push_rec),
    .push     (push)
  );

  sfcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  sfcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
